// File: design/mmg_pkg.sv
// ----------------------------------------------------------------------------
// mmg_pkg: shared constants and types
// Store sizing, queue sizing, the item struct and the back-end state codes.
// ----------------------------------------------------------------------------
package mmg_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned POS_BITS  = 30;
  localparam int unsigned NEED_W    = 11;
  localparam int unsigned AW        = $clog2(MAX_ITEMS);
  localparam int unsigned CW        = AW + 1;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QAW       = $clog2(QDEPTH);

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic                last;
  } mmg_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PLACE, S_SHIFT, S_PUT0,
    S_FIN0, S_LO, S_HI, S_MID, S_WALK, S_JUDGE
  } mmg_state_e;

endpackage

// File: design/mmg_if.sv
// ----------------------------------------------------------------------------
// mmg_if: request channels
// Input channel (position, last_item) and result channel (best_gap, overflowed).
// ----------------------------------------------------------------------------
interface mmg_in_if import mmg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] position;
  logic                last_item;
  modport source (output valid, position, last_item, input ready);
  modport sink   (input valid, position, last_item, output ready);
endinterface

interface mmg_out_if import mmg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] best_gap;
  logic                overflowed;
  modport source (output valid, best_gap, overflowed, input ready);
  modport sink   (input valid, best_gap, overflowed, output ready);
endinterface

// File: design/mmg_ram.sv
// ----------------------------------------------------------------------------
// mmg_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mmg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/mmg_front.sv
// ----------------------------------------------------------------------------
// mmg_front: input queue
// Takes position requests and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module mmg_front import mmg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mmg_in_if.sink    in_chan,
  output logic      q_valid_o,
  input  logic      q_ready_i,
  output mmg_item_t q_item_o
);

  mmg_item_t          buf_q [QDEPTH];
  logic [QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QAW:0]       cnt_q;
  logic               push, pop;

  assign in_chan.ready = (cnt_q != QAW'(0) + (QAW+1)'(QDEPTH)) ? 1'b1 : 1'b0;
  assign push          = in_chan.valid & in_chan.ready;
  assign q_valid_o     = (cnt_q != '0);
  assign pop           = q_valid_o & q_ready_i;
  assign q_item_o      = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= '{pos: in_chan.position, last: in_chan.last_item};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QAW'(1);
      cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

// File: design/mmg_back.sv
// ----------------------------------------------------------------------------
// mmg_back: store, sort and gap search
// Insertion-sorts each position into the RAM as it arrives; on the closing
// item binary-searches the gap with one greedy walk over the RAM per step.
// ----------------------------------------------------------------------------
module mmg_back import mmg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NEED_W-1:0] need_i,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  mmg_item_t         q_item_i,
  mmg_out_if.source         out_chan
);

  mmg_state_e          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic                last_q, last_d;
  logic [AW-1:0]       j_q, j_d;
  logic [POS_BITS-1:0] first_q, first_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [POS_BITS-1:0] prev_q, prev_d;
  logic [CW-1:0]       picked_q, picked_d;
  logic                ov_q, ov_d;
  logic [POS_BITS-1:0] gap_q, gap_d;
  logic                ovo_q, ovo_d;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [POS_BITS-1:0] wdata, rdata;
  logic [POS_BITS:0]   half;
  logic                at_end;

  mmg_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_ITEMS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_chan.valid      = ov_q;
  assign out_chan.best_gap   = gap_q;
  assign out_chan.overflowed = ovo_q;

  assign half   = ({1'b0, hi_q} - {1'b0, lo_q} + (POS_BITS+1)'(1)) >> 1;
  assign at_end = ({1'b0, j_q} == cnt_q - CW'(1));

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    pos_d    = pos_q;
    last_d   = last_q;
    j_d      = j_q;
    first_d  = first_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    prev_d   = prev_q;
    picked_d = picked_q;
    ov_d     = ov_q & ~out_chan.ready;
    gap_d    = gap_q;
    ovo_d    = ovo_q;
    q_ready_o = 1'b0;
    we       = 1'b0;
    waddr    = j_q;
    wdata    = pos_q;
    raddr    = '0;
    unique case (state_q)
      S_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          pos_d   = q_item_i.pos;
          last_d  = q_item_i.last;
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        if (cnt_q == CW'(MAX_ITEMS)) begin
          ovf_d   = 1'b1;
          state_d = last_q ? S_FIN0 : S_IDLE;
        end else if (cnt_q == '0) begin
          we      = 1'b1;
          waddr   = '0;
          cnt_d   = cnt_q + CW'(1);
          state_d = last_q ? S_FIN0 : S_IDLE;
        end else begin
          j_d     = cnt_q[AW-1:0];
          raddr   = cnt_q[AW-1:0] - AW'(1);
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = j_q;
        if (rdata > pos_q) begin
          wdata = rdata;
          j_d   = j_q - AW'(1);
          raddr = j_q - AW'(2);
          if (j_q == AW'(1)) state_d = S_PUT0;
        end else begin
          wdata   = pos_q;
          cnt_d   = cnt_q + CW'(1);
          state_d = last_q ? S_FIN0 : S_IDLE;
        end
      end
      S_PUT0: begin
        we      = 1'b1;
        waddr   = '0;
        cnt_d   = cnt_q + CW'(1);
        state_d = last_q ? S_FIN0 : S_IDLE;
      end
      S_FIN0: begin
        // wait for the result register to drain
        if (!ov_q) begin
          if (cnt_q < CW'(2)) begin
            lo_d    = '0;
            hi_d    = '0;
            state_d = S_MID;
          end else begin
            raddr   = '0;
            state_d = S_LO;
          end
        end
      end
      S_LO: begin
        first_d = rdata;
        raddr   = cnt_q[AW-1:0] - AW'(1);
        state_d = S_HI;
      end
      S_HI: begin
        hi_d    = rdata - first_q;
        lo_d    = '0;
        state_d = S_MID;
      end
      S_MID: begin
        if (lo_q < hi_q) begin
          mid_d    = lo_q + half[POS_BITS-1:0];
          prev_d   = first_q;
          picked_d = CW'(1);
          j_d      = AW'(1);
          raddr    = AW'(1);
          state_d  = S_WALK;
        end else begin
          gap_d   = lo_q;
          ovo_d   = ovf_q;
          ov_d    = 1'b1;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (rdata - prev_q >= mid_q) begin
          prev_d   = rdata;
          picked_d = picked_q + CW'(1);
        end
        if (at_end) begin
          state_d = S_JUDGE;
        end else begin
          j_d   = j_q + AW'(1);
          raddr = j_q + AW'(1);
        end
      end
      S_JUDGE: begin
        if ({1'b0, picked_q} >= (CW+1)'(need_i)) lo_d = mid_q;
        else                                      hi_d = mid_q - POS_BITS'(1);
        state_d = S_MID;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    last_q   <= last_d;
    j_q      <= j_d;
    first_q  <= first_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    prev_q   <= prev_d;
    picked_q <= picked_d;
    gap_q    <= gap_d;
    ovo_q    <= ovo_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS)) else $error("store count past capacity");
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> ({1'b0, j_q} < cnt_q)) else $error("walk past set");
  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (cnt_q != '0)) else $error("shift in empty store");
  a_walk_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cnt_q >= CW'(2))) else $error("walk with under two points");

endmodule

// File: design/max_min_gap_placement.sv
// ----------------------------------------------------------------------------
// max_min_gap_placement: largest minimum gap for a placement of points
// Loads positions, sorts them and searches the largest achievable gap.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one position request per handshake; last_item closes the
//   set. out_chan returns one result (best_gap, overflowed) per closed set.
//   cfg_we_i/cfg_data_i write points_to_place (reset 2) while idle.
// Timing:
//   A four-entry queue takes requests while the back end works. Each stored
//   position is insertion-sorted into the RAM, moving each larger entry up by
//   one place. Closing a set runs a binary search of at most 30 steps, each a
//   greedy walk over the stored points, bound by one RAM read per cycle.
//   Positions beyond 1024 are dropped and reported through overflowed.
// Reset: queue, count and flags clear; the RAM needs no clearing.
// Stall: the result register holds until taken; the next set keeps loading
//   but does not start its search until the result has gone.
// ----------------------------------------------------------------------------
module max_min_gap_placement import mmg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  mmg_in_if.sink            in_chan,
  mmg_out_if.source         out_chan,
  input  logic              cfg_we_i,
  input  logic [NEED_W-1:0] cfg_data_i
);

  logic [NEED_W-1:0] need_q;
  logic              q_valid, q_ready;
  mmg_item_t         q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= NEED_W'(2);
    end else if (cfg_we_i) begin
      need_q <= cfg_data_i;
    end
  end

  mmg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .q_valid_o(q_valid),
    .q_ready_i(q_ready),
    .q_item_o (q_item)
  );

  mmg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .need_i   (need_q),
    .q_valid_i(q_valid),
    .q_ready_o(q_ready),
    .q_item_i (q_item),
    .out_chan (out_chan)
  );

endmodule
